// ===== src/bcd_pkg.sv =====
`timescale 1ns / 1ps
package bcd_pkg;

  localparam int MAX_DIMENSION = 16384;
  localparam int DIM_W  = $clog2(MAX_DIMENSION) + 1;   // config width/height field
  localparam int BLK_W  = $clog2(MAX_DIMENSION / 4);   // block column / row counter
  localparam int BCNT_W = BLK_W + 1;                   // block count, may equal 2**BLK_W
  localparam int COORD_W = 14;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] CFG_FORMAT = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  localparam logic [1:0] FMT_BC1 = 2'd0;
  localparam logic [1:0] FMT_BC2 = 2'd1;

  typedef logic [2:0][7:0] rgb_t;

  // first stage: endpoints expanded, alpha numerators weighted
  typedef struct packed {
    logic [1:0]        fmt;
    logic              four;
    rgb_t              e0;
    rgb_t              e1;
    logic [7:0]        a0;
    logic [7:0]        a1;
    logic              agt;
    logic [5:0][10:0]  anum;    // numerators of alpha entries 2..7
    logic [63:0]       abits;
    logic [31:0]       codes;
    logic [15:0]       mask;
    logic [BLK_W-1:0]  col;
    logic [BLK_W-1:0]  row;
  } bcd_s1_t;

  // one queued block, palette resolved
  typedef struct packed {
    logic [1:0]        fmt;
    logic              trans;
    logic [3:0][23:0]  pal;
    logic [7:0][7:0]   alut;
    logic [63:0]       abits;
    logic [31:0]       codes;
    logic [15:0]       mask;
    logic [BLK_W-1:0]  col;
    logic [BLK_W-1:0]  row;
  } bcd_entry_t;

  // v*255/31 as one reciprocal multiply
  function automatic logic [7:0] exp5(input logic [4:0] v);
    logic [28:0] p;
    p = 29'(v) * 29'd8625630;
    return p[27:20];
  endfunction

  // v*255/63
  function automatic logic [7:0] exp6(input logic [5:0] v);
    logic [28:0] p;
    p = 29'(v) * 29'd4244475;
    return p[27:20];
  endfunction

  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [24:0] p;
    p = 25'(x) * 25'd21846;
    return p[23:16];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [24:0] p;
    p = 25'(x) * 25'd13108;
    return p[23:16];
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [24:0] p;
    p = 25'(x) * 25'd9363;
    return p[23:16];
  endfunction

endpackage

// ===== src/bcd_if.sv =====
`timescale 1ns / 1ps
interface bcd_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] alpha_bits;
  logic [63:0] color_bits;
  modport source(output valid, alpha_bits, color_bits, input ready);
  modport sink(input valid, alpha_bits, color_bits, output ready);
endinterface

interface bcd_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] pixel_x;
  logic [13:0] pixel_y;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic        last_of_block;
  modport source(output valid, pixel_x, pixel_y, red, green, blue, alpha, last_of_block,
                 input ready);
  modport sink(input valid, pixel_x, pixel_y, red, green, blue, alpha, last_of_block,
               output ready);
endinterface

// ===== src/bcd_front.sv =====
`timescale 1ns / 1ps
module bcd_front import bcd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data,
  bcd_in_if.sink      in_ch,
  input  logic        q_full,
  output logic        q_push,
  output bcd_entry_t  q_wdata
);

  logic [1:0]       fmt_r;
  logic [DIM_W-1:0] width_r, height_r;
  logic [BLK_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  bcd_s1_t          s1_r, s1_nxt;

  logic [DIM_W-1:0]  w_cl, h_cl;
  logic [BCNT_W-1:0] bx_cnt, by_cnt, col_inc, row_inc;
  logic [BLK_W-1:0]  col_eff, row_eff;
  logic [15:0]       c0, c1;
  logic [7:0]        a0, a1;
  logic [COORD_W-1:0] px, py;
  logic              accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FMT_BC1;
      width_r  <= DIM_W'(4);
      height_r <= DIM_W'(4);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FORMAT: fmt_r    <= cfg_data[1:0];
        CFG_WIDTH:  width_r  <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT: height_r <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_cl = width_r;
    if (width_r == '0) w_cl = DIM_W'(1);
    else if (width_r > DIM_W'(MAX_DIMENSION)) w_cl = DIM_W'(MAX_DIMENSION);
    h_cl = height_r;
    if (height_r == '0) h_cl = DIM_W'(1);
    else if (height_r > DIM_W'(MAX_DIMENSION)) h_cl = DIM_W'(MAX_DIMENSION);
  end

  assign bx_cnt = BCNT_W'((DIM_W'(3) + w_cl) >> 2);
  assign by_cnt = BCNT_W'((DIM_W'(3) + h_cl) >> 2);

  assign in_ch.ready = !s1_valid_r || !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // counters left outside the image by a size change restart at zero
  assign col_eff = (BCNT_W'(col_r) >= bx_cnt) ? '0 : col_r;
  assign row_eff = (BCNT_W'(row_r) >= by_cnt) ? '0 : row_r;
  assign col_inc = BCNT_W'(col_eff) + BCNT_W'(1);
  assign row_inc = BCNT_W'(row_eff) + BCNT_W'(1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_inc >= bx_cnt) begin
        col_nxt = '0;
        row_nxt = (row_inc >= by_cnt) ? '0 : row_inc[BLK_W-1:0];
      end else begin
        col_nxt = col_inc[BLK_W-1:0];
        row_nxt = row_eff;
      end
    end
  end

  assign c0 = in_ch.color_bits[15:0];
  assign c1 = in_ch.color_bits[31:16];
  assign a0 = in_ch.alpha_bits[7:0];
  assign a1 = in_ch.alpha_bits[15:8];

  always_comb begin
    s1_nxt       = s1_r;
    s1_nxt.fmt   = fmt_r;
    s1_nxt.four  = !(fmt_r == FMT_BC1 && c0 <= c1);
    s1_nxt.e0    = {exp5(c0[15:11]), exp6(c0[10:5]), exp5(c0[4:0])};
    s1_nxt.e1    = {exp5(c1[15:11]), exp6(c1[10:5]), exp5(c1[4:0])};
    s1_nxt.a0    = a0;
    s1_nxt.a1    = a1;
    s1_nxt.agt   = a0 > a1;
    s1_nxt.abits = in_ch.alpha_bits;
    s1_nxt.codes = in_ch.color_bits[63:32];
    s1_nxt.col   = col_eff;
    s1_nxt.row   = row_eff;
    px = '0;
    py = '0;
    for (int j = 0; j < 6; j++) begin
      // entry j+2 weights a0 and a1 by (7-k, k) or (5-k, k), k = j+1
      if (a0 > a1)
        s1_nxt.anum[j] = 11'(6 - j) * 11'(a0) + 11'(j + 1) * 11'(a1);
      else if (j < 4)
        s1_nxt.anum[j] = 11'(4 - j) * 11'(a0) + 11'(j + 1) * 11'(a1);
      else
        s1_nxt.anum[j] = '0;
    end
    for (int i = 0; i < 16; i++) begin
      px = {col_eff, 2'(i & 3)};
      py = {row_eff, 2'(i >> 2)};
      s1_nxt.mask[i] = (DIM_W'(px) < w_cl) && (DIM_W'(py) < h_cl);
    end
  end

  assign s1_valid_nxt = accept || (s1_valid_r && q_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) s1_r <= s1_nxt;
  end

  // second stage: palette interpolation straight into the queue
  assign q_push = s1_valid_r && !q_full;

  always_comb begin
    q_wdata       = '0;
    q_wdata.fmt   = s1_r.fmt;
    q_wdata.trans = !s1_r.four;
    q_wdata.abits = s1_r.abits;
    q_wdata.codes = s1_r.codes;
    q_wdata.mask  = s1_r.mask;
    q_wdata.col   = s1_r.col;
    q_wdata.row   = s1_r.row;
    q_wdata.pal[0] = s1_r.e0;
    q_wdata.pal[1] = s1_r.e1;
    for (int k = 0; k < 3; k++) begin
      if (s1_r.four) begin
        q_wdata.pal[2][k*8 +: 8] = div3({1'b0, s1_r.e0[k], 1'b0} + 10'(s1_r.e1[k]));
        q_wdata.pal[3][k*8 +: 8] = div3(10'(s1_r.e0[k]) + {1'b0, s1_r.e1[k], 1'b0});
      end else begin
        q_wdata.pal[2][k*8 +: 8] = 8'((9'(s1_r.e0[k]) + 9'(s1_r.e1[k])) >> 1);
        q_wdata.pal[3][k*8 +: 8] = 8'h00;
      end
    end
    q_wdata.alut[0] = s1_r.a0;
    q_wdata.alut[1] = s1_r.a1;
    for (int j = 0; j < 6; j++) begin
      if (s1_r.agt) q_wdata.alut[j+2] = div7(s1_r.anum[j]);
      else if (j < 4) q_wdata.alut[j+2] = div5(s1_r.anum[j]);
      else if (j == 4) q_wdata.alut[j+2] = 8'h00;
      else q_wdata.alut[j+2] = 8'hFF;
    end
  end

endmodule

// ===== src/bcd_queue.sv =====
`timescale 1ns / 1ps
module bcd_queue import bcd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  bcd_entry_t wdata,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output bcd_entry_t rdata
);

  bcd_entry_t        mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = cnt_r == QCNT_W'(QDEPTH);
  assign empty = cnt_r == '0;
  assign rdata = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    if (push && !pop) cnt_nxt = cnt_r + QCNT_W'(1);
    else if (pop && !push) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wdata;
  end

endmodule

// ===== src/bcd_back.sv =====
`timescale 1ns / 1ps
module bcd_back import bcd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  bcd_entry_t q_rdata,
  output logic       q_pop,
  bcd_out_if.source  out_ch
);

  logic [3:0]  idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [COORD_W-1:0] px_r, py_r;
  logic [7:0]  red_r, green_r, blue_r, alpha_r;
  logic        last_r;

  logic        slot_free, pix_ok, no_more, step, load;
  logic [15:0] above;
  logic [1:0]  ci;
  logic [3:0]  nib;
  logic [2:0]  aidx;
  logic [23:0] rgb;
  logic [7:0]  alpha_v;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign pix_ok    = q_rdata.mask[idx_r];
  assign above     = q_rdata.mask >> idx_r;
  assign no_more   = above[15:1] == '0;    // nothing left to emit after this pixel
  assign step      = !q_empty && (!pix_ok || slot_free);
  assign load      = !q_empty && pix_ok && slot_free;
  assign q_pop     = step && (no_more || idx_r == 4'hF);
  assign idx_nxt   = q_pop ? '0 : (step ? idx_r + 4'd1 : idx_r);

  assign ci   = q_rdata.codes[{idx_r, 1'b0} +: 2];
  assign nib  = q_rdata.abits[{idx_r, 2'b00} +: 4];
  assign aidx = q_rdata.abits[6'd16 + 6'(idx_r) * 6'd3 +: 3];
  assign rgb  = q_rdata.pal[ci];

  always_comb begin
    priority if (q_rdata.fmt == FMT_BC1)
      alpha_v = (q_rdata.trans && ci == 2'h3) ? 8'h00 : 8'hFF;
    else if (q_rdata.fmt == FMT_BC2)
      alpha_v = {nib, nib};
    else
      alpha_v = q_rdata.alut[aidx];
  end

  assign out_valid_nxt = load || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      px_r    <= {q_rdata.col, idx_r[1:0]};
      py_r    <= {q_rdata.row, idx_r[3:2]};
      red_r   <= rgb[23:16];
      green_r <= rgb[15:8];
      blue_r  <= rgb[7:0];
      alpha_r <= alpha_v;
      last_r  <= no_more;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pixel_x       = px_r;
  assign out_ch.pixel_y       = py_r;
  assign out_ch.red           = red_r;
  assign out_ch.green         = green_r;
  assign out_ch.blue          = blue_r;
  assign out_ch.alpha         = alpha_r;
  assign out_ch.last_of_block = last_r;

endmodule

// ===== src/bc1_bc2_bc3_block_decoder.sv =====
`timescale 1ns / 1ps
// BC1/BC2/BC3 block decoder: takes one compressed 4x4 block per request, in raster block
// order, and emits its pixels as RGBA8 in raster order inside the block, one pixel per
// cycle unless out_ch.ready stalls it, with last_of_block on the final pixel emitted
// for that block. Clipped pixels at the right or bottom edge are not emitted but still
// take a step unless no emitted pixel follows them. Blocks wait in a registered endpoint
// stage and a two-entry queue whose head is being emitted, so up to three blocks are held
// inside; a block passes the endpoint stage, queue and output register before its first
// pixel is offered. Format, width and height must be written through the cfg port only
// while the decoder is idle, which it does not enforce. Block position wraps at image end.
module bc1_bc2_bc3_block_decoder import bcd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data,
  bcd_in_if.sink      in_ch,
  bcd_out_if.source   out_ch
);

  logic       q_push, q_full, q_pop, q_empty;
  bcd_entry_t q_wdata, q_rdata;

  bcd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  bcd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  bcd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_rdata (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
